// ----- rtl/core/keyed_slot_table_macros.svh -----
// ============================================================================
// Keyed slot table assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ============================================================================
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH

// Same-cycle implication.
`define KST_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define KST_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/kst_pkg.sv -----
// ============================================================================
// Keyed slot table package
// Sizes, codes and word types shared by the table's modules.
// ============================================================================
package kst_pkg;

    // Number of slots and the width of a slot number.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 63;
    localparam int WORD_W  = 64;
    localparam int SLOT_W  = 4;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_idx IDX_LAST = t_idx'(ENTRIES - 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_GET   = 2'd1,
        OP_SET   = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ALREADY = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Request word.
    typedef struct packed {
        t_op   operation;
        t_key  owner_key;
        t_word data_in;
    } t_req;

    // Result word.
    typedef struct packed {
        t_status status;
        t_word   data_out;
        t_slot   slot_index;
    } t_rsp;

    // Access to the key memory.
    typedef struct packed {
        logic re;
        logic we;
        t_idx addr;
        t_key wdata;
    } t_key_port;

    // Access to the data memory.
    typedef struct packed {
        logic  re;
        logic  we;
        t_idx  addr;
        t_word wdata;
    } t_data_port;

    // The reported slot number is the low SLOT_W bits of the zero-extended slot index.
    function automatic t_slot to_slot_index(input t_idx idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/kst_ram.sv -----
// ============================================================================
// Keyed slot table RAM
// Single-port synchronous RAM with a registered read.
// ============================================================================
module kst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read share the one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/kst_ctrl.sv -----
// ============================================================================
// Keyed slot table sequencer
// Scans the key memory one slot a cycle, then carries out the command and answers.
// ============================================================================
`include "keyed_slot_table_macros.svh"

module kst_ctrl import kst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_rsp       o_rsp,
    output t_key_port  o_key_port,
    input  t_key       i_key_rdata,
    output t_data_port o_data_port,
    input  t_word      i_data_rdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_EXEC  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_idx              r_addr, n_addr;
    logic              r_cmp_on, n_cmp_on;
    t_idx              r_cmp_idx, n_cmp_idx;
    logic              r_hit, n_hit;
    t_idx              r_hit_idx, n_hit_idx;
    logic              r_free, n_free;
    t_idx              r_free_idx, n_free_idx;
    t_req              r_req, n_req;
    t_status           r_status, n_status;
    t_idx              r_idx, n_idx;
    logic              r_get, n_get;

    // Next-state and memory access logic.
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_addr     = r_addr;
        n_cmp_on   = r_cmp_on;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_req      = r_req;
        n_status   = r_status;
        n_idx      = r_idx;
        n_get      = r_get;

        o_key_port.re     = (r_state == S_SCAN);
        o_key_port.we     = 1'b0;
        o_key_port.addr   = r_addr;
        o_key_port.wdata  = r_req.owner_key;
        o_data_port.re    = 1'b0;
        o_data_port.we    = 1'b0;
        o_data_port.addr  = (r_req.operation == OP_ALLOC) ? r_free_idx : r_hit_idx;
        o_data_port.wdata = '0;

        // Compare the key read in the previous cycle; keep the lowest hit
        // and the lowest free slot.
        if (r_cmp_on) begin
            if (r_valid[r_cmp_idx] && (i_key_rdata == r_req.owner_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (!r_valid[r_cmp_idx] && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_addr   = '0;
                    n_cmp_on = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_on  = 1'b1;
                n_cmp_idx = r_addr;
                if (r_addr == IDX_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + t_idx'(1);
                end
            end
            S_DRAIN: begin
                n_cmp_on = 1'b0;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_get   = 1'b0;
                n_idx   = '0;
                n_state = S_RESP;
                case (r_req.operation)
                    OP_ALLOC: begin
                        if (r_hit) begin
                            n_status = ST_ALREADY;
                            n_idx    = r_hit_idx;
                        end else if (r_free) begin
                            // Claim the slot with a cleared data word.
                            n_status            = ST_DONE;
                            n_idx               = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                            o_key_port.we       = 1'b1;
                            o_key_port.addr     = r_free_idx;
                            o_data_port.we      = 1'b1;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    OP_GET: begin
                        if (r_hit) begin
                            n_status       = ST_DONE;
                            n_idx          = r_hit_idx;
                            n_get          = 1'b1;
                            o_data_port.re = 1'b1;
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    OP_SET: begin
                        if (r_hit) begin
                            n_status          = ST_DONE;
                            n_idx             = r_hit_idx;
                            o_data_port.we    = 1'b1;
                            o_data_port.wdata = r_req.data_in;
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    OP_FREE: begin
                        if (r_hit) begin
                            n_status           = ST_DONE;
                            n_idx              = r_hit_idx;
                            n_valid[r_hit_idx] = 1'b0;
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    default: begin
                        n_status = ST_MISSING;
                    end
                endcase
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; the request and scan results are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cmp_on <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_cmp_on <= n_cmp_on;
        end
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_req      <= n_req;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_get      <= n_get;
    end

    // Result word; data only comes back for a successful get.
    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.data_out    = r_get ? i_data_rdata : '0;
    assign o_rsp.slot_index  = to_slot_index(r_idx);

    `KST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `KST_ASSERT_IMP(a_resp_after_exec, o_strobe, $past(r_state) == S_EXEC, "result without update step")
    `KST_ASSERT_IMP(a_err_zero, o_strobe && (o_rsp.status == ST_FULL || o_rsp.status == ST_MISSING), o_rsp.slot_index == '0 && o_rsp.data_out == '0, "error result not zeroed")
    `KST_ASSERT_IMP(a_claim_free, o_key_port.we, !r_valid[o_key_port.addr] && r_req.operation == OP_ALLOC, "key written over a live slot")

endmodule

// ----- rtl/core/keyed_slot_table.sv -----
// ============================================================================
// Keyed slot table
// Associative table of owner keys and data words with allocate, get, set
// and free commands.
// ============================================================================
//
//  Channel   Ports                    Handshake
//  request   start, busy, i_req       taken at an edge with start high, busy low
//  result    o_strobe, o_rsp          valid one cycle with o_strobe, no stall
//
// For each word the key memory's single read port scans one slot per cycle,
// then S_DRAIN finishes the last compare, S_EXEC carries out the command on
// the slot and S_RESP answers.
// busy stays high until the result cycle ends; one word is in work at a time.
// Reset clears the valid bits in flip-flops, so the block needs no clearing
// pass and can accept a word as soon as reset is released.
// The receiver cannot stall; the result is shown for exactly one cycle.
//
module keyed_slot_table import kst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_key_port  key_port;
    t_data_port data_port;
    t_key       key_rdata;
    t_word      data_rdata;

    // Sequencer with the valid bits.
    kst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_strobe     (o_strobe),
        .o_rsp        (o_rsp),
        .o_key_port   (key_port),
        .i_key_rdata  (key_rdata),
        .o_data_port  (data_port),
        .i_data_rdata (data_rdata)
    );

    // Owner keys.
    kst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_re    (key_port.re),
        .i_we    (key_port.we),
        .i_addr  (key_port.addr),
        .i_wdata (key_port.wdata),
        .o_rdata (key_rdata)
    );

    // Data words.
    kst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_re    (data_port.re),
        .i_we    (data_port.we),
        .i_addr  (data_port.addr),
        .i_wdata (data_port.wdata),
        .o_rdata (data_rdata)
    );

endmodule
